@@ rtl/fletcher64_checksum_defines.svh @@
// Assertion macros shared by the checksum checker.
`ifndef FLETCHER64_CHECKSUM_DEFINES_SVH
`define FLETCHER64_CHECKSUM_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define F64C_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("f64c: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define F64C_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("f64c: next-cycle check failed");

`endif

@@ rtl/f64c_pkg.sv @@
// Types, constants and the end-around adder for the Fletcher-64 block.
`timescale 1ns / 1ps

package f64c_pkg;

    localparam logic [31:0] SUM_MODULUS    = 32'hFFFF_FFFF;
    localparam int          BYTES_PER_WORD = 4;
    localparam logic [1:0]  LAST_POS       = 2'(BYTES_PER_WORD - 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic  valid;
        beat_t beat;
    } stage_t;

    // (x + y) mod (2^32 - 1) for x below the modulus and any 32-bit y.
    function automatic logic [31:0] mod_add(input logic [31:0] x, input logic [31:0] y);
        logic [32:0] sum;
        logic [31:0] wrapped;
        begin
            sum     = {1'b0, x} + {1'b0, y};
            wrapped = sum[31:0] + {31'b0, sum[32]};
            mod_add = (wrapped == SUM_MODULUS) ? 32'h0 : wrapped;
        end
    endfunction

endpackage

@@ rtl/fletcher64_checksum.sv @@
// Top level of the Fletcher-64 checksum block.
// Takes one message byte per beat and returns the 64-bit checksum (second sum
// in bits 63..32, first sum in bits 31..0) on m_checksum after the beat marked
// s_last. A beat is registered on entry, passes through one stage that packs
// the byte and performs the two chained end-around adds, and the checksum is
// registered on the way out, so m_valid rises once the closing beat has left
// the entry register and its checksum is captured. Throughput is one beat per
// cycle; s_ready drops only when the entry register holds a closing beat while
// an earlier checksum still waits to be taken. A closing beat without a byte
// ends the message, so an empty message gives 0.
`timescale 1ns / 1ps

module fletcher64_checksum (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_checksum
);

    f64c_pkg::beat_t  in_beat;
    f64c_pkg::stage_t stage;
    logic             advance;
    logic [63:0]      checksum;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [63:0]      checksum_reg;
    logic             emit;

    assign in_beat.data_byte    = s_data_byte;
    assign in_beat.byte_present = s_byte_present;
    assign in_beat.last         = s_last;

    // A closing beat waits only while the result register is still occupied.
    assign advance = stage.valid && (!stage.beat.last || !out_valid_reg || m_ready);
    assign emit    = advance && stage.beat.last;

    f64c_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_beat (in_beat),
        .advance (advance),
        .stage   (stage)
    );

    f64c_accum u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .beat     (stage.beat),
        .checksum (checksum)
    );

    always_comb begin
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            checksum_reg <= checksum;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_checksum = checksum_reg;

endmodule

@@ rtl/f64c_in_stage.sv @@
// Input register stage: captures one beat and holds it until the sum stage takes it.
`timescale 1ns / 1ps

module f64c_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  f64c_pkg::beat_t in_beat,
    input  logic            advance,
    output f64c_pkg::stage_t stage
);

    logic            valid_reg;
    logic            valid_next;
    f64c_pkg::beat_t beat_reg;
    logic            load;

    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= in_beat;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.beat  = beat_reg;

endmodule

@@ rtl/f64c_accum.sv @@
// Running sums, word packing and the checksum of a closing beat.
`timescale 1ns / 1ps

module f64c_accum (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  f64c_pkg::beat_t beat,
    output logic [63:0]     checksum
);

    logic [31:0] first_sum_reg;
    logic [31:0] first_sum_next;
    logic [31:0] second_sum_reg;
    logic [31:0] second_sum_next;
    logic [23:0] partial_word_reg;
    logic [23:0] partial_word_next;
    logic [1:0]  byte_position_reg;
    logic [1:0]  byte_position_next;

    logic [31:0] word;
    logic        word_full;
    logic [23:0] partial_after;
    logic [1:0]  pos_after;
    logic        fold;
    logic [31:0] fold_word;
    logic [31:0] first_after;
    logic [31:0] second_after;

    // Drop the byte into its lane of the word.
    always_comb begin
        case (byte_position_reg)
            2'd0:    word = {8'h0, partial_word_reg[23:8], beat.data_byte};
            2'd1:    word = {8'h0, partial_word_reg[23:16], beat.data_byte,
                             partial_word_reg[7:0]};
            2'd2:    word = {8'h0, beat.data_byte, partial_word_reg[15:0]};
            default: word = {beat.data_byte, partial_word_reg};
        endcase
    end

    assign word_full = beat.byte_present && (byte_position_reg == f64c_pkg::LAST_POS);

    always_comb begin
        if (!beat.byte_present) begin
            partial_after = partial_word_reg;
            pos_after     = byte_position_reg;
        end else if (word_full) begin
            partial_after = 24'h0;
            pos_after     = 2'd0;
        end else begin
            partial_after = word[23:0];
            pos_after     = byte_position_reg + 2'd1;
        end
    end

    // A full word folds as is; a closing beat folds the zero-padded partial word, if any.
    assign fold      = word_full || (beat.last && (pos_after != 2'd0));
    assign fold_word = word_full ? word : {8'h0, partial_after};

    assign first_after  = fold ? f64c_pkg::mod_add(first_sum_reg, fold_word)
                               : first_sum_reg;
    assign second_after = fold ? f64c_pkg::mod_add(second_sum_reg, first_after)
                               : second_sum_reg;

    assign checksum = {second_after, first_after};

    always_comb begin
        if (beat.last) begin
            first_sum_next     = 32'h0;
            second_sum_next    = 32'h0;
            partial_word_next  = 24'h0;
            byte_position_next = 2'd0;
        end else begin
            first_sum_next     = first_after;
            second_sum_next    = second_after;
            partial_word_next  = partial_after;
            byte_position_next = pos_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_sum_reg     <= 32'h0;
            second_sum_reg    <= 32'h0;
            partial_word_reg  <= 24'h0;
            byte_position_reg <= 2'd0;
        end else if (step) begin
            first_sum_reg     <= first_sum_next;
            second_sum_reg    <= second_sum_next;
            partial_word_reg  <= partial_word_next;
            byte_position_reg <= byte_position_next;
        end
    end

endmodule

@@ rtl/f64c_checker.sv @@
// Port-level checker for the Fletcher-64 block, bound to the top level.
`timescale 1ns / 1ps
`include "fletcher64_checksum_defines.svh"

module f64c_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_checksum
);

    // Closing beats accepted whose checksum has not yet been delivered.
    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       close_in;
    logic       result_out;

    assign close_in   = s_valid && s_ready && s_last;
    assign result_out = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg + {2'b0, close_in} - {2'b0, result_out};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 3'd0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    `F64C_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_checksum))
    `F64C_ASSERT_NOW(a_halves_reduced, aclk, aresetn, m_valid,
        (m_checksum[31:0] != 32'hFFFF_FFFF) && (m_checksum[63:32] != 32'hFFFF_FFFF))
    `F64C_ASSERT_NOW(a_no_invented_result, aclk, aresetn, m_valid, pending_reg != 3'd0)
    `F64C_ASSERT_NOW(a_pending_bounded, aclk, aresetn, 1'b1, pending_reg <= 3'd2)

endmodule

bind fletcher64_checksum f64c_checker u_f64c_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_last     (s_last),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_checksum (m_checksum)
);
